@@ sv/prqs_pkg.sv @@
// Package for the priority ready-queue scheduler: sizes, command and status codes.
// No dependencies.
package prqs_pkg;
    localparam int THREADS_DEF = 32;
    localparam int LEVELS_DEF  = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int PRIO_W      = 5;
    localparam int TID_W       = 5;
    localparam int QUANT_W     = 8;
    localparam int REFILL_W    = 7;
    localparam logic [4:0] BOOST_CEIL_RST = 5'd15;
    localparam logic [6:0] REFILL_RST     = 7'd3;

    typedef enum logic [1:0] {
        CMD_MARK_READY = 2'd0,
        CMD_REMOVE     = 2'd1,
        CMD_PICK       = 2'd2,
        CMD_SET_PRIO   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_ALREADY_READY = 3'd1,
        ST_NOTHING_READY = 3'd2,
        ST_SUSPENDED     = 3'd3,
        ST_NOT_READY     = 3'd4
    } status_t;

    typedef enum logic {
        REG_BOOST_CEIL = 1'b0,
        REG_REFILL     = 1'b1
    } reg_idx_t;

    // Members listed from the highest bit down: status lands in the lowest bits
    typedef struct packed {
        logic       preempt_request;
        logic [4:0] thread_priority;
        logic [4:0] picked_thread;
        status_t    status;
    } result_t;
endpackage

@@ sv/priority_ready_queue_scheduler_unit.sv @@
// Top level of the priority ready-queue scheduler: command register, queue state,
// single-pass update and result register. Uses prqs_pkg.
//
// A command passes through the input register, then the result register (its result
// beat). Throughput: one command per cycle unless the result beat is stalled; the queue
// state update of one command completes before the next leaves the input register.
// Reset: all threads not ready, all queues empty, boost_ceiling 15, refill_quantum 3.
module priority_ready_queue_scheduler_unit #(
    parameter int THREADS = prqs_pkg::THREADS_DEF,
    parameter int LEVELS  = prqs_pkg::LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], thread_id[6:2], charge[10:7], boost[15:11], new_priority[20:16],
    // running_priority[25:21], suspended[26], zero fill [31:27]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], picked_thread[7:3], thread_priority[12:8], preempt_request[13], zero fill
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);
    localparam int LW = $clog2(THREADS + 1);   // link width incl. none
    localparam int PW = $clog2(LEVELS);
    localparam logic [LW-1:0] NONE = LW'(THREADS);

    // state
    logic [4:0]         dyn_reg  [THREADS];
    logic [4:0]         base_reg [THREADS];
    logic [7:0]         quant_reg[THREADS];
    logic [THREADS-1:0] rdy_reg;
    logic [LW-1:0]      nxt_reg  [THREADS];
    logic [LW-1:0]      prv_reg  [THREADS];
    logic [LW-1:0]      head_reg [LEVELS];
    logic [LW-1:0]      tail_reg [LEVELS];
    logic [LEVELS-1:0]  bmp_reg;
    logic [4:0]         ceil_reg;
    logic [6:0]         refill_reg;

    logic [4:0]         dyn_next  [THREADS];
    logic [4:0]         base_next [THREADS];
    logic [7:0]         quant_next[THREADS];
    logic [THREADS-1:0] rdy_next;
    logic [LW-1:0]      nxt_next  [THREADS];
    logic [LW-1:0]      prv_next  [THREADS];
    logic [LW-1:0]      head_next [LEVELS];
    logic [LW-1:0]      tail_next [LEVELS];
    logic [LEVELS-1:0]  bmp_next;

    // pipeline
    logic        in_vld_reg;
    logic [26:0] in_reg;
    logic        out_vld_reg;
    prqs_pkg::result_t out_reg, res;

    assign s_tready  = !out_vld_reg || m_tready || !in_vld_reg;
    assign cfg_ready = 1'b1;
    logic adv;
    assign adv = !out_vld_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceil_reg   <= prqs_pkg::BOOST_CEIL_RST;
            refill_reg <= prqs_pkg::REFILL_RST;
        end
        else if (cfg_valid)
        begin
            case (prqs_pkg::reg_idx_t'(cfg_index))
                prqs_pkg::REG_BOOST_CEIL: ceil_reg   <= cfg_data[4:0];
                prqs_pkg::REG_REFILL:     refill_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage and result stage
    logic go;
    assign go = in_vld_reg && adv;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_vld_reg <= 1'b1;
            else if (go)
                in_vld_reg <= 1'b0;
            if (go)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= s_tdata[26:0];
        if (go)
            out_reg <= res;
    end
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_reg};

    // command decode
    prqs_pkg::cmd_t cmd;
    logic [4:0] tid, boost, newp_in, running;
    logic [3:0] charge;
    logic       susp;
    assign cmd     = prqs_pkg::cmd_t'(in_reg[1:0]);
    assign tid     = in_reg[6:2];
    assign charge  = in_reg[10:7];
    assign boost   = in_reg[15:11];
    assign newp_in = in_reg[20:16];
    assign running = in_reg[25:21];
    assign susp    = in_reg[26];

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdy_reg <= '0;
            bmp_reg <= '0;
            for (int i = 0; i < THREADS; i++)
            begin
                dyn_reg[i] <= '0; base_reg[i] <= '0; quant_reg[i] <= '0;
                nxt_reg[i] <= NONE; prv_reg[i] <= NONE;
            end
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= NONE; tail_reg[i] <= NONE;
            end
        end
        else if (go)
        begin
            rdy_reg <= rdy_next;
            bmp_reg <= bmp_next;
            dyn_reg <= dyn_next; base_reg <= base_next; quant_reg <= quant_next;
            nxt_reg <= nxt_next; prv_reg <= prv_next;
            head_reg <= head_next; tail_reg <= tail_next;
        end
    end

    function automatic logic [PW-1:0] lvl(input logic [4:0] p);
        lvl = (32'(p) < LEVELS) ? PW'(p) : PW'(LEVELS - 1);
    endfunction

    // single-pass command logic
    always_comb
    begin
        logic [LW-1:0]    t, n, pv, h, tl;
        logic [PW-1:0]    p, top;
        logic             found, unl, enq;
        logic signed [9:0] q;
        logic [5:0]       np;
        logic [4:0]       ceil, newp;
        dyn_next = dyn_reg; base_next = base_reg; quant_next = quant_reg;
        rdy_next = rdy_reg; nxt_next = nxt_reg; prv_next = prv_reg;
        head_next = head_reg; tail_next = tail_reg; bmp_next = bmp_reg;
        res = '{status: prqs_pkg::ST_OK, picked_thread: tid,
                thread_priority: 5'd0, preempt_request: 1'b0};
        t = LW'(tid); unl = 1'b0; enq = 1'b0;
        n = NONE; pv = NONE; h = NONE; tl = NONE; p = '0;
        q = '0; np = '0; ceil = '0;
        top = '0; found = 1'b0;
        for (int i = 0; i < LEVELS; i++)
            if (bmp_reg[i]) begin top = PW'(i); found = 1'b1; end
        newp = (32'(newp_in) > LEVELS - 1) ? 5'(LEVELS - 1) : newp_in;
        if (cmd == prqs_pkg::CMD_PICK)
        begin
            res.picked_thread = '0;
            if (!found)
                res.status = prqs_pkg::ST_NOTHING_READY;
            else if (head_reg[top] == NONE)
            begin
                bmp_next[top] = 1'b0;
                res.status = prqs_pkg::ST_NOTHING_READY;
            end
            else
            begin
                t = head_reg[top]; unl = 1'b1;
                res.picked_thread = 5'(t);
            end
        end
        else if (32'(tid) >= THREADS)
            res.status = prqs_pkg::ST_NOT_READY;
        else if (cmd == prqs_pkg::CMD_MARK_READY)
        begin
            if (susp)
            begin
                unl = rdy_reg[t[LW-2:0]];
                res.status = prqs_pkg::ST_SUSPENDED;
            end
            else if (rdy_reg[t[LW-2:0]])
                res.status = prqs_pkg::ST_ALREADY_READY;
            else
                enq = 1'b1;
        end
        else if (cmd == prqs_pkg::CMD_REMOVE)
        begin
            if (rdy_reg[t[LW-2:0]]) unl = 1'b1;
            else res.status = prqs_pkg::ST_NOT_READY;
        end
        else if (base_reg[t[LW-2:0]] != newp)
        begin
            if (rdy_reg[t[LW-2:0]])
            begin
                unl = 1'b1;
                if (susp) res.status = prqs_pkg::ST_SUSPENDED;
                else enq = 1'b1;
            end
        end
        // unlink uses the old level
        if (unl)
        begin
            p  = lvl(dyn_reg[t[LW-2:0]]);
            n  = nxt_reg[t[LW-2:0]];
            pv = prv_reg[t[LW-2:0]];
            if (n != NONE) prv_next[n[LW-2:0]] = pv;
            if (pv != NONE) nxt_next[pv[LW-2:0]] = n;
            if (head_reg[p] == t) head_next[p] = n;
            if (tail_reg[p] == t) tail_next[p] = pv;
            if (tail_next[p] == NONE) bmp_next[p] = 1'b0;
            nxt_next[t[LW-2:0]] = NONE;
            prv_next[t[LW-2:0]] = NONE;
            rdy_next[t[LW-2:0]] = 1'b0;
        end
        // a new base priority also resets the dynamic one; the same base keeps both
        if (cmd == prqs_pkg::CMD_SET_PRIO && 32'(tid) < THREADS
            && base_reg[t[LW-2:0]] != newp)
        begin
            base_next[t[LW-2:0]] = newp;
            dyn_next[t[LW-2:0]]  = newp;
        end
        // enqueue against post-unlink queue state
        if (enq)
        begin
            q = 10'(signed'(quant_reg[t[LW-2:0]]));
            if (cmd == prqs_pkg::CMD_MARK_READY) q = q - 10'(charge);
            if (q < -10'sd128) q = -10'sd128;
            ceil = (32'(ceil_reg) < LEVELS) ? ceil_reg : 5'(LEVELS - 1);
            np = (cmd == prqs_pkg::CMD_MARK_READY)
                 ? 6'(base_next[t[LW-2:0]]) + 6'(boost) : 6'(base_next[t[LW-2:0]]);
            if (np > 6'(ceil)) np = 6'(ceil);
            if (np > 6'(dyn_next[t[LW-2:0]])) dyn_next[t[LW-2:0]] = 5'(np);
            rdy_next[t[LW-2:0]] = 1'b1;
            if (q > 0)
            begin
                quant_next[t[LW-2:0]] = 8'(q);
                p = lvl(dyn_next[t[LW-2:0]]);
                h = head_next[p];
                prv_next[t[LW-2:0]] = NONE;
                nxt_next[t[LW-2:0]] = h;
                if (h == NONE)
                begin
                    tail_next[p] = t; bmp_next[p] = 1'b1;
                end
                else
                    prv_next[h[LW-2:0]] = t;
                head_next[p] = t;
            end
            else
            begin
                quant_next[t[LW-2:0]] = {1'b0, refill_reg};
                if (dyn_next[t[LW-2:0]] > base_next[t[LW-2:0]])
                    dyn_next[t[LW-2:0]] = dyn_next[t[LW-2:0]] - 5'd1;
                p = lvl(dyn_next[t[LW-2:0]]);
                tl = tail_next[p];
                nxt_next[t[LW-2:0]] = NONE;
                prv_next[t[LW-2:0]] = tl;
                if (tl == NONE)
                begin
                    head_next[p] = t; bmp_next[p] = 1'b1;
                end
                else
                    nxt_next[tl[LW-2:0]] = t;
                tail_next[p] = t;
            end
            res.preempt_request = dyn_next[t[LW-2:0]] > running;
        end
        if (res.status != prqs_pkg::ST_NOTHING_READY && !(32'(tid) >= THREADS
            && cmd != prqs_pkg::CMD_PICK))
            res.thread_priority = dyn_next[t[LW-2:0]];
    end

    // checks
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped while stalled");
    a_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        go && cmd == prqs_pkg::CMD_PICK && bmp_reg == '0 |=>
        out_reg.status == prqs_pkg::ST_NOTHING_READY)
        else $error("pick on empty bitmap");
    a_bmp: assert property (@(posedge clk) disable iff (!rst_n)
        (rdy_reg == '0) |-> (bmp_reg == '0))
        else $error("bitmap set with no ready thread");
endmodule
